FILE: rtl/i2cmra_pkg.sv
// shared types and constants of the i2c master register access unit
// no dependencies

package i2cmra_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [6:0] DEV_ADDR_RST    = 7'd104;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  localparam logic REG_DEV_ADDR    = 1'b0;
  localparam logic REG_PHASE_TICKS = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ADDR_NACK = 2'd1;
  localparam logic [1:0] STAT_REG_NACK  = 2'd2;
  localparam logic [1:0] STAT_DATA_NACK = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_STA_A = 4'd1,
    PH_STA_B = 4'd2,
    PH_WB_H  = 4'd3,
    PH_WB_L  = 4'd4,
    PH_ACK_L = 4'd5,
    PH_ACK_H = 4'd6,
    PH_RB_L  = 4'd7,
    PH_RB_H  = 4'd8,
    PH_MA_L  = 4'd9,
    PH_MA_H  = 4'd10,
    PH_STO_A = 4'd11,
    PH_STO_B = 4'd12
  } phase_e;

  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_DATA   = 2'd2,
    STG_ADDR_R = 2'd3
  } stage_e;

  typedef struct packed {
    logic       start_request;
    logic       mode;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic       sda_level;
  } in_beat_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_enable;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       byte_last;
    logic       done_res;
    logic [1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] phase_ticks;
  } cfg_t;

endpackage

FILE: rtl/i2cmra_cfg.sv
// apb configuration registers: device address and ticks per phase
// depends on i2cmra_pkg

module i2cmra_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cmra_pkg::PADDR_W-1:0]   paddr,
  input  logic [i2cmra_pkg::PDATA_W-1:0]   pwdata,
  output logic [i2cmra_pkg::PDATA_W-1:0]   prdata,
  output logic                             pready,
  output i2cmra_pkg::cfg_t                 cfg_o
);
  import i2cmra_pkg::*;

  logic [6:0] dev_addr_q, dev_addr_d;
  logic [7:0] phase_ticks_q, phase_ticks_d;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    dev_addr_d    = dev_addr_q;
    phase_ticks_d = phase_ticks_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_DEV_ADDR:    dev_addr_d    = pwdata[6:0];
        REG_PHASE_TICKS: phase_ticks_d = pwdata[7:0];
        default:         dev_addr_d    = dev_addr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RST;
      phase_ticks_q <= PHASE_TICKS_RST;
    end else begin
      dev_addr_q    <= dev_addr_d;
      phase_ticks_q <= phase_ticks_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEV_ADDR:    prdata = {{(PDATA_W-7){1'b0}}, dev_addr_q};
      REG_PHASE_TICKS: prdata = {{(PDATA_W-8){1'b0}}, phase_ticks_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.device_address = dev_addr_q;
  assign cfg_o.phase_ticks    = phase_ticks_q;

endmodule

FILE: rtl/i2cmra_seq.sv
// bus sequencer: phase state, bit and byte counters, one tick per beat
// depends on i2cmra_pkg

module i2cmra_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  i2cmra_pkg::in_beat_t   beat_i,
  input  i2cmra_pkg::cfg_t       cfg_i,
  output i2cmra_pkg::out_beat_t  res_o,
  output logic                   idle_o
);
  import i2cmra_pkg::*;

  phase_e     phase_q, phase_d, cur;
  stage_e     stage_q, stage_d;
  logic [7:0] tick_q, tick_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] left_q, left_d;
  logic [7:0] hreg_q, hreg_d;
  logic [7:0] hdata_q, hdata_d;
  logic       hmode_q, hmode_d;
  logic [1:0] hstat_q, hstat_d;
  logic [7:0] ticks;
  logic       last_tick;
  logic       sda;

  function automatic logic [7:0] load_val(stage_e s, logic [6:0] dev,
                                          logic [7:0] rg, logic [7:0] dt);
    logic [7:0] v;
    unique case (s)
      STG_ADDR_W: v = {dev, 1'b0};
      STG_REG:    v = rg;
      STG_DATA:   v = dt;
      STG_ADDR_R: v = {dev, 1'b1};
      default:    v = {dev, 1'b1};
    endcase
    return v;
  endfunction

  assign ticks  = (cfg_i.phase_ticks == 8'd0) ? 8'd1 : cfg_i.phase_ticks;
  assign sda    = beat_i.sda_level;
  assign idle_o = (phase_q == PH_IDLE);

  always_comb begin
    phase_d = phase_q;
    stage_d = stage_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    left_d  = left_q;
    hreg_d  = hreg_q;
    hdata_d = hdata_q;
    hmode_d = hmode_q;
    hstat_d = hstat_q;
    cur     = phase_q;
    last_tick = 1'b0;
    res_o = '0;
    res_o.scl_level  = 1'b1;
    res_o.sda_drive  = 1'b1;
    res_o.sda_enable = 1'b1;

    if (phase_q == PH_IDLE && beat_i.start_request) begin
      hmode_d = beat_i.mode;
      hreg_d  = beat_i.register_address;
      hdata_d = beat_i.write_data;
      left_d  = beat_i.read_length;
      hstat_d = STAT_OK;
      stage_d = STG_ADDR_W;
      tick_d  = 8'd0;
      phase_d = PH_STA_A;
    end

    if (phase_d != PH_IDLE) begin
      cur = phase_d;
      res_o.busy_res = 1'b1;
      unique case (cur)
        PH_STA_A: begin
          res_o.scl_level = 1'b1; res_o.sda_drive = 1'b1;
        end
        PH_STA_B: begin
          res_o.scl_level = 1'b1; res_o.sda_drive = 1'b0;
        end
        PH_WB_H: begin
          res_o.scl_level = 1'b1; res_o.sda_drive = shift_d[7];
        end
        PH_WB_L: begin
          res_o.scl_level = 1'b0; res_o.sda_drive = shift_d[7];
        end
        PH_ACK_L, PH_RB_L: begin
          res_o.scl_level = 1'b0; res_o.sda_enable = 1'b0;
        end
        PH_ACK_H, PH_RB_H: begin
          res_o.scl_level = 1'b1; res_o.sda_enable = 1'b0;
        end
        PH_MA_L: begin
          res_o.scl_level = 1'b0; res_o.sda_drive = (left_d == 8'd1);
        end
        PH_MA_H: begin
          res_o.scl_level = 1'b1; res_o.sda_drive = (left_d == 8'd1);
        end
        PH_STO_A: begin
          res_o.scl_level = 1'b0; res_o.sda_drive = 1'b0;
        end
        PH_STO_B: begin
          res_o.scl_level = 1'b1; res_o.sda_drive = 1'b0;
        end
        default: phase_d = PH_IDLE;
      endcase

      // read data bit sampled at the start of scl high
      if (cur == PH_RB_H && tick_d == 8'd0) begin
        shift_d = {shift_d[6:0], sda};
      end

      last_tick = ({1'b0, tick_d} + 9'd1) >= {1'b0, ticks};
      if (phase_d != PH_IDLE && !last_tick) begin
        tick_d = tick_d + 8'd1;
      end else if (phase_d != PH_IDLE) begin
        tick_d = 8'd0;
        unique case (cur)
          PH_STA_A: phase_d = PH_STA_B;
          PH_STA_B: begin
            shift_d = load_val(stage_d, cfg_i.device_address, hreg_d, hdata_d);
            bit_d   = 4'd0;
            phase_d = PH_WB_H;
          end
          PH_WB_H: phase_d = PH_WB_L;
          PH_WB_L: begin
            shift_d = {shift_d[6:0], 1'b0};
            bit_d   = bit_d + 4'd1;
            phase_d = (bit_d >= BITS_PER_BYTE) ? PH_ACK_L : PH_WB_H;
          end
          PH_ACK_L: phase_d = PH_ACK_H;
          PH_ACK_H: begin
            if (sda) begin
              unique case (stage_d)
                STG_ADDR_W: hstat_d = STAT_ADDR_NACK;
                STG_REG:    hstat_d = STAT_REG_NACK;
                default:    hstat_d = STAT_DATA_NACK;
              endcase
              phase_d = PH_STO_A;
            end else begin
              unique case (stage_d)
                STG_ADDR_W: begin
                  stage_d = STG_REG;
                  shift_d = load_val(STG_REG, cfg_i.device_address, hreg_d, hdata_d);
                  bit_d   = 4'd0;
                  phase_d = PH_WB_H;
                end
                STG_REG: begin
                  if (hmode_d) begin
                    stage_d = STG_ADDR_R;
                    phase_d = PH_STA_A;
                  end else begin
                    stage_d = STG_DATA;
                    shift_d = load_val(STG_DATA, cfg_i.device_address, hreg_d, hdata_d);
                    bit_d   = 4'd0;
                    phase_d = PH_WB_H;
                  end
                end
                STG_DATA: phase_d = PH_STO_A;
                default: begin
                  if (left_d == 8'd0) begin
                    phase_d = PH_STO_A;
                  end else begin
                    bit_d   = 4'd0;
                    shift_d = 8'd0;
                    phase_d = PH_RB_L;
                  end
                end
              endcase
            end
          end
          PH_RB_L: phase_d = PH_RB_H;
          PH_RB_H: begin
            bit_d   = bit_d + 4'd1;
            phase_d = (bit_d >= BITS_PER_BYTE) ? PH_MA_L : PH_RB_L;
          end
          PH_MA_L: phase_d = PH_MA_H;
          PH_MA_H: begin
            res_o.byte_valid = 1'b1;
            res_o.read_byte  = shift_d;
            res_o.byte_last  = (left_d == 8'd1);
            left_d = left_d - 8'd1;
            if (left_d == 8'd0) begin
              phase_d = PH_STO_A;
            end else begin
              bit_d   = 4'd0;
              shift_d = 8'd0;
              phase_d = PH_RB_L;
            end
          end
          PH_STO_A: phase_d = PH_STO_B;
          PH_STO_B: begin
            res_o.done_res = 1'b1;
            res_o.status   = hstat_d;
            phase_d = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      if (!res_o.sda_enable) begin
        res_o.sda_drive = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      stage_q <= STG_ADDR_W;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      hreg_q  <= '0;
      hdata_q <= '0;
      hmode_q <= 1'b0;
      hstat_q <= STAT_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      stage_q <= stage_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      hreg_q  <= hreg_d;
      hdata_q <= hdata_d;
      hmode_q <= hmode_d;
      hstat_q <= hstat_d;
    end
  end

endmodule

FILE: rtl/i2c_master_register_access_unit.sv
// top level of the i2c master register access unit: input and result registers
// depends on i2cmra_pkg, i2cmra_cfg, i2cmra_seq
//
// usage: every input beat is one bus tick carrying the sampled sda level and an
// optional start command with its transaction fields; every input beat yields
// exactly one result beat with the scl/sda levels to drive, busy, read byte
// strobe and done/status.
// channels: in_* and out_* use valid/stall; a beat moves when valid is high and
// stall is low. the user sets device address and ticks per phase over the apb
// port (byte addresses 0 and 4) while no transaction is running; not enforced.
// an accepted beat lands in the input register; its result is registered in
// the output register, which drives out_*.
// throughput: one beat per cycle unless the result is stalled; the sequencer
// state updates in the same cycle the result register loads, one tick per beat.
// stall: a stalled result holds in the output register; the input register still
// fills behind it, and in_stall_o rises only when both registers are full.
// reset: state goes idle, both registers empty, device address 104 and one tick
// per phase.

module i2c_master_register_access_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  i2cmra_pkg::in_beat_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output i2cmra_pkg::out_beat_t            out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cmra_pkg::PADDR_W-1:0]   paddr,
  input  logic [i2cmra_pkg::PDATA_W-1:0]   pwdata,
  output logic [i2cmra_pkg::PDATA_W-1:0]   prdata,
  output logic                             pready
);
  import i2cmra_pkg::*;

  in_beat_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_beat_t out_q, res;
  logic      out_vld_q, out_vld_d;
  logic      step;
  logic      in_take;
  logic      seq_idle;
  cfg_t      cfg;

  i2cmra_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cmra_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res),
    .idle_o (seq_idle)
  );

  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // empty input register never stalls the sender
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  // an idle tick without a start gives a result that is not busy
  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && seq_idle && !in_q.start_request) |=> !out_data_o.busy_res)
    else $error("idle tick reported busy");

  // a received byte comes only mid transaction, never on the done tick
  a_byte_in_txn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_valid) |-> (out_data_o.busy_res && !out_data_o.done_res))
    else $error("byte strobe outside a running transaction");

  // a done tick returns the sequencer to idle
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.done_res) |=> seq_idle)
    else $error("sequencer not idle after done");

endmodule
